// ===== rtl/vsa_pkg.sv =====
// Package for the vector statistics accumulator: item types, the snapshot
// passed from the front to the back, the sequencer states and shared widths.
// No dependencies.
package vsa_pkg;

  localparam int MAX_COUNT   = 65536;
  localparam int QUEUE_DEPTH = 2;

  localparam int COUNT_W = 17;
  localparam int SUM_W   = 32;
  localparam int SUMSQ_W = 47;
  localparam int SMP_W   = 16;
  localparam int EUCL_W  = 24;

  // Iterative units: square root of a 64-bit radicand, 32 by 17 divide.
  localparam int SQRT_W    = 64;
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = COUNT_W;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } vsa_smp_t;

  typedef struct packed {
    logic        [COUNT_W-1:0] count;
    logic signed [SUM_W-1:0]   total;
    logic signed [SMP_W-1:0]   mean;
    logic signed [SMP_W-1:0]   minimum;
    logic        [EUCL_W-1:0]  euclid_length;
    logic        [SMP_W-1:0]   std_dev;
    logic                      overflow;
  } vsa_res_t;

  // Accumulator contents at the end of one vector.
  typedef struct packed {
    logic        [COUNT_W-1:0] count;
    logic signed [SUM_W-1:0]   total;
    logic        [SUMSQ_W-1:0] sumsq;
    logic signed [SMP_W-1:0]   minimum;
    logic                      overflow;
  } vsa_snap_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_VAR_SUM,
    ST_VAR_SUB,
    ST_WAIT_FIRST,
    ST_ROOT_VAR,
    ST_DIV_SD,
    ST_OUT
  } vsa_state_t;

endpackage

// ===== rtl/vector_statistics_accumulator_core.sv =====
// Top level of the vector statistics accumulator.
// Depends on vsa_pkg, vsa_front, vsa_queue and vsa_back.

// The block takes one signed sample per cycle on the smp channel while the
// queue is not full and, on the item marked last, produces one result on the
// res channel with the count, sum, mean, minimum, Euclidean length and
// population standard deviation of the vector. Samples past 65536 elements
// are dropped and flagged. Within a vector the front accepts an item every
// cycle while the queue is not full. Each vector end occupies the back for
// the shared bit-serial square root (on the sum of squares, overlapped with
// the mean divide, then on the variance) and the divide for the deviation. A
// queue of QUEUE_DEPTH vector snapshots sits between front and back, so
// vectors shorter than the back's work stall the input once the queue fills.
module vector_statistics_accumulator_core #(
  parameter int QUEUE_DEPTH = vsa_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              smp_valid,
  output logic              smp_ready,
  input  vsa_pkg::vsa_smp_t smp_item,
  output logic              res_valid,
  input  logic              res_ready,
  output vsa_pkg::vsa_res_t res_item
);

  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  vsa_pkg::vsa_snap_t push_data;
  vsa_pkg::vsa_snap_t pop_data;

  vsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_item  (smp_item),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  vsa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  vsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop       (pop),
    .pop_data  (pop_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

// ===== rtl/vsa_front.sv =====
// Front of the vector statistics accumulator: takes sample items, keeps the
// running count, sum, sum of squares and minimum, and pushes a snapshot at
// vector end. Depends on vsa_pkg.
module vsa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               smp_valid,
  output logic               smp_ready,
  input  vsa_pkg::vsa_smp_t  smp_item,
  output logic               push,
  output vsa_pkg::vsa_snap_t push_data,
  input  logic               full
);

  logic        [vsa_pkg::COUNT_W-1:0] elem_count;
  logic signed [vsa_pkg::SUM_W-1:0]   running_sum;
  logic        [vsa_pkg::SUMSQ_W-1:0] running_sumsq;
  logic signed [vsa_pkg::SMP_W-1:0]   running_min;
  logic                               overflow_seen;

  logic signed [31:0] square;
  logic               room;
  logic               accept;
  vsa_pkg::vsa_snap_t snap_next;

  assign smp_ready = !full;
  assign accept    = smp_valid && smp_ready;
  assign room      = elem_count < vsa_pkg::COUNT_W'(vsa_pkg::MAX_COUNT);
  assign square    = 32'(smp_item.sample) * 32'(smp_item.sample);

  always_comb begin
    snap_next.count    = elem_count;
    snap_next.total    = running_sum;
    snap_next.sumsq    = running_sumsq;
    snap_next.minimum  = running_min;
    snap_next.overflow = overflow_seen;
    if (room) begin
      snap_next.count = elem_count + vsa_pkg::COUNT_W'(1);
      snap_next.total = running_sum + vsa_pkg::SUM_W'(smp_item.sample);
      snap_next.sumsq = running_sumsq + vsa_pkg::SUMSQ_W'($unsigned(square));
      if (smp_item.sample < running_min) begin
        snap_next.minimum = smp_item.sample;
      end
    end else begin
      snap_next.overflow = 1'b1;
    end
  end

  assign push      = accept && smp_item.last;
  assign push_data = snap_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      elem_count    <= '0;
      running_sum   <= '0;
      running_sumsq <= '0;
      running_min   <= vsa_pkg::SMP_W'(32767);
      overflow_seen <= 1'b0;
    end else if (accept) begin
      elem_count    <= snap_next.count;
      running_sum   <= snap_next.total;
      running_sumsq <= snap_next.sumsq;
      running_min   <= snap_next.minimum;
      overflow_seen <= snap_next.overflow;
    end
  end

endmodule

// ===== rtl/vsa_queue.sv =====
// Short snapshot queue between the front and the back of the accumulator.
// Depends on vsa_pkg.
module vsa_queue #(
  parameter int DEPTH = vsa_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vsa_pkg::vsa_snap_t push_data,
  output logic               full,
  input  logic               pop,
  output vsa_pkg::vsa_snap_t pop_data,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vsa_pkg::vsa_snap_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full     = fill == CW'(DEPTH);
  assign empty    = fill == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/vsa_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle, floored result.
// Depends on vsa_pkg.
module vsa_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [vsa_pkg::SQRT_W-1:0]   radicand,
  output logic                         busy,
  output logic [vsa_pkg::SQRT_W/2-1:0] root
);

  localparam int W    = vsa_pkg::SQRT_W;
  localparam int HALF = W / 2;
  localparam int IW   = $clog2(HALF + 1);

  logic [W-1:0]    rad;
  logic [HALF:0]   rem;
  logic [IW-1:0]   iter;
  logic [HALF+2:0] rem_sh;
  logic [HALF+2:0] trial;
  logic [HALF+2:0] diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem, rad[W-1 -: 2]};
    trial  = (HALF + 3)'({root, 2'b01});
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= IW'(HALF);
    end else if (busy) begin
      iter <= iter - IW'(1);
      if (iter == IW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? diff[HALF:0] : rem_sh[HALF:0];
      root <= {root[HALF-2:0], ge};
    end
  end

endmodule

// ===== rtl/vsa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vsa_pkg.
module vsa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vsa_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [vsa_pkg::DIV_DEN_W-1:0] divisor,
  output logic                          busy,
  output logic [vsa_pkg::DIV_NUM_W-1:0] quotient
);

  localparam int NW = vsa_pkg::DIV_NUM_W;
  localparam int DW = vsa_pkg::DIV_DEN_W;
  localparam int IW = $clog2(NW + 1);

  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [IW-1:0] iter;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem, quotient[NW-1]};
    ge     = rem_sh >= {1'b0, den};
    diff   = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= IW'(NW);
    end else if (busy) begin
      iter <= iter - IW'(1);
      if (iter == IW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

// ===== rtl/vsa_back.sv =====
// Back of the vector statistics accumulator: takes snapshots from the queue,
// sequences the multiplies, square roots and divides, and holds the result.
// Depends on vsa_pkg, vsa_isqrt and vsa_div.
module vsa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  output logic               pop,
  input  vsa_pkg::vsa_snap_t pop_data,
  output logic               res_valid,
  input  logic               res_ready,
  output vsa_pkg::vsa_res_t  res_item
);

  vsa_pkg::vsa_state_t state;
  vsa_pkg::vsa_state_t state_next;

  logic        [vsa_pkg::COUNT_W-1:0] cnt;
  logic        [vsa_pkg::SUMSQ_W-1:0] sumsq;
  logic signed [vsa_pkg::SUM_W-1:0]   tot;
  logic signed [vsa_pkg::SMP_W-1:0]   minv;
  logic                               ovf;
  logic                               neg;
  logic        [31:0]                 amag;
  logic        [40:0]                 prod_lo;
  logic        [39:0]                 prod_hi;
  logic        [63:0]                 sq;
  logic        [63:0]                 var_sum;
  logic        [63:0]                 var_r;
  logic        [64:0]                 var_diff;
  logic        [vsa_pkg::EUCL_W-1:0]  euclid;
  logic signed [vsa_pkg::SMP_W-1:0]   mean;
  logic        [vsa_pkg::SMP_W-1:0]   sd;
  logic        [31:0]                 load_mag;

  logic                                 sqrt_start;
  logic [vsa_pkg::SQRT_W-1:0]           sqrt_in;
  logic                                 sqrt_busy;
  logic [vsa_pkg::SQRT_W/2-1:0]         sqrt_root;
  logic                                 div_start;
  logic [vsa_pkg::DIV_NUM_W-1:0]        div_num;
  logic                                 div_busy;
  logic [vsa_pkg::DIV_NUM_W-1:0]        div_quo;
  logic                                 res_load;
  logic                                 first_done;

  assign first_done = !sqrt_busy && !div_busy;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      vsa_pkg::ST_IDLE:       if (!empty) state_next = vsa_pkg::ST_MUL_LO;
      vsa_pkg::ST_MUL_LO:     state_next = vsa_pkg::ST_MUL_HI;
      vsa_pkg::ST_MUL_HI:     state_next = vsa_pkg::ST_VAR_SUM;
      vsa_pkg::ST_VAR_SUM:    state_next = vsa_pkg::ST_VAR_SUB;
      vsa_pkg::ST_VAR_SUB:    state_next = vsa_pkg::ST_WAIT_FIRST;
      vsa_pkg::ST_WAIT_FIRST: if (first_done) state_next = vsa_pkg::ST_ROOT_VAR;
      vsa_pkg::ST_ROOT_VAR:   if (!sqrt_busy) state_next = vsa_pkg::ST_DIV_SD;
      vsa_pkg::ST_DIV_SD:     if (!div_busy) state_next = vsa_pkg::ST_OUT;
      vsa_pkg::ST_OUT:        if (!res_valid || res_ready) state_next = vsa_pkg::ST_IDLE;
      default:                state_next = vsa_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer. The first root and the mean divide run while
  // the variance is being formed.
  always_comb begin
    pop        = 1'b0;
    sqrt_start = 1'b0;
    sqrt_in    = var_r;
    div_start  = 1'b0;
    div_num    = vsa_pkg::DIV_NUM_W'(sqrt_root);
    res_load   = 1'b0;
    case (state)
      vsa_pkg::ST_IDLE: begin
        pop = !empty;
      end
      vsa_pkg::ST_MUL_LO: begin
        sqrt_start = 1'b1;
        sqrt_in    = vsa_pkg::SQRT_W'(sumsq);
        div_start  = 1'b1;
        div_num    = amag;
      end
      vsa_pkg::ST_WAIT_FIRST: begin
        sqrt_start = first_done;
      end
      vsa_pkg::ST_ROOT_VAR: begin
        div_start = !sqrt_busy;
      end
      vsa_pkg::ST_OUT: begin
        res_load = !res_valid || res_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign load_mag = pop_data.total[31] ? 32'(-pop_data.total) : 32'(pop_data.total);
  assign var_diff = {1'b0, var_sum} - {1'b0, sq};

  always_ff @(posedge clk) begin
    case (state)
      vsa_pkg::ST_IDLE: begin
        cnt   <= pop_data.count;
        sumsq <= pop_data.sumsq;
        tot   <= pop_data.total;
        minv  <= pop_data.minimum;
        ovf   <= pop_data.overflow;
        neg   <= pop_data.total[31];
        amag  <= load_mag;
      end
      vsa_pkg::ST_MUL_LO: begin
        prod_lo <= 41'(cnt) * 41'(sumsq[23:0]);
        sq      <= 64'(amag) * 64'(amag);
      end
      vsa_pkg::ST_MUL_HI: begin
        prod_hi <= 40'(cnt) * 40'(sumsq[46:24]);
      end
      vsa_pkg::ST_VAR_SUM: begin
        var_sum <= {prod_hi, 24'b0} + 64'(prod_lo);
      end
      vsa_pkg::ST_VAR_SUB: begin
        // A borrow means the variance term went negative; clamp it to zero.
        var_r <= var_diff[64] ? 64'b0 : var_diff[63:0];
      end
      vsa_pkg::ST_WAIT_FIRST: begin
        if (first_done) begin
          euclid <= sqrt_root[vsa_pkg::EUCL_W-1:0];
          mean   <= neg ? -div_quo[vsa_pkg::SMP_W-1:0] : div_quo[vsa_pkg::SMP_W-1:0];
        end
      end
      vsa_pkg::ST_DIV_SD: begin
        if (!div_busy) begin
          sd <= div_quo[vsa_pkg::SMP_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_item.count         <= cnt;
      res_item.total         <= tot;
      res_item.mean          <= mean;
      res_item.minimum       <= minv;
      res_item.euclid_length <= euclid;
      res_item.std_dev       <= sd;
      res_item.overflow      <= ovf;
    end
  end

  vsa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  vsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cnt),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

// ===== rtl/vsa_checker.sv =====
// Port-level checks for the vector statistics accumulator, bound to the top.
// Depends on vsa_pkg and vector_statistics_accumulator_core.
module vsa_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input vsa_pkg::vsa_res_t res_item
);

  // A stalled result item holds its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // Every result counts at least one element and never more than the limit.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.count != '0 &&
                  (!res_item.count[16] || res_item.count[15:0] == '0))
    else $error("result count out of range");

  // Elements are dropped only once the vector is full.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.overflow |->
      res_item.count == vsa_pkg::COUNT_W'(vsa_pkg::MAX_COUNT))
    else $error("overflow flagged on a vector that is not full");

  // The mean, truncated toward zero, never drops below the minimum.
  a_min_mean: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.minimum <= res_item.mean)
    else $error("minimum above mean");

endmodule

bind vector_statistics_accumulator_core vsa_checker u_vsa_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);
